>>> design/assert_macros.svh
// Assertion helpers included by the heap queue design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, muted while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/hbpq_pkg.sv
package hbpq_pkg;

  typedef struct packed {
    logic        [31:0] key;
    logic signed [31:0] tag;
    logic        [15:0] size;
  } entry_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

>>> design/hbpq_mem.sv
module hbpq_mem import hbpq_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output entry_t        rd_data_a,
  output entry_t        rd_data_b
);

  entry_t mem [DEPTH];

  // One write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> design/hbpq_cmp.sv
module hbpq_cmp import hbpq_pkg::*; (
  input  entry_t a,
  input  entry_t b,
  input  logic   max_first,
  output logic   a_worse
);

  logic [63:0] rank_a;
  logic [63:0] rank_b;

  // Key first, then tag with its sign bit flipped so it orders as unsigned.
  assign rank_a = {a.key, ~a.tag[31], a.tag[30:0]};
  assign rank_b = {b.key, ~b.tag[31], b.tag[30:0]};

  assign a_worse = max_first ? (rank_a < rank_b) : (rank_a > rank_b);

endmodule

>>> design/binary_heap_priority_queue.sv
// Binary heap priority queue: one item in, one result out per item.
// Insert: the item is walked up one heap level per parent read and compare step until it settles.
// Remove: the last entry moves to the root and walks down one level per read, select and compare step.
// Steps are paced by the shared comparator and the registered memory read; a new item is taken only in idle.
// Synchronous active-high reset empties the queue and selects min-first order;
// the heap memory itself is not cleared and needs no clearing pass.
module binary_heap_priority_queue import hbpq_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  // item input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic        [31:0] sort_key,
  input  logic signed [31:0] tag_value,
  input  logic        [15:0] item_size,
  // result output
  output logic               out_valid,
  input  logic               out_ready,
  output logic         [1:0] status,
  output logic        [31:0] out_key,
  output logic signed [31:0] out_tag,
  output logic        [15:0] out_size,
  output logic         [8:0] entry_count
);

  `include "assert_macros.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_SEL,
    S_DN_CMP,
    S_FIN
  } state_t;

  state_t        state;
  logic [CW-1:0] count;          // entries held, updated when the item is taken
  logic          order_max_first;
  entry_t        item;           // entry being inserted, or the moved last entry
  entry_t        best;           // better child of the hole
  logic [AW-1:0] hole;
  logic [AW-1:0] best_idx;
  entry_t        res;
  logic [1:0]    res_status;

  // memory and comparator hookup
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  entry_t        rd_a;
  entry_t        rd_b;
  entry_t        cmp_a;
  entry_t        cmp_b;
  logic          a_worse;

  // heap index arithmetic (0-based slots)
  logic [AW-1:0] up_parent;
  logic [AW:0]   dn_left;
  logic [AW:0]   dn_right;
  logic [XW-1:0] count_ext;
  logic          left_ok;
  logic          right_ok;
  logic [CW+8:0] count_wide;

  assign up_parent = (hole - 1'b1) >> 1;
  assign dn_left   = {hole, 1'b1};
  assign dn_right  = dn_left + 1'b1;
  assign count_ext = {{(XW-CW){1'b0}}, count};
  assign left_ok   = {1'b0, dn_left} < count_ext;
  assign right_ok  = {1'b0, dn_right} < count_ext;

  assign in_ready  = (state == S_IDLE);

  hbpq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (mem_wdata),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  hbpq_cmp u_cmp (
    .a         (cmp_a),
    .b         (cmp_b),
    .max_first (order_max_first),
    .a_worse   (a_worse)
  );

  // Steer the single comparator and the memory ports by sequencer state.
  always_comb begin
    cmp_a     = rd_a;
    cmp_b     = rd_b;
    mem_we    = 1'b0;
    mem_waddr = hole;
    mem_wdata = item;
    rd_addr_a = '0;
    rd_addr_b = count[AW-1:0] - 1'b1;
    case (state)
      S_IDLE: begin
        // Root and last slot are fetched on every idle cycle; a remove uses them.
      end
      S_UP_RD: begin
        if (hole == '0) begin
          mem_we = 1'b1;
        end else begin
          rd_addr_a = up_parent;
        end
      end
      S_UP_CMP: begin
        cmp_a  = rd_a;
        cmp_b  = item;
        mem_we = 1'b1;
        if (a_worse) begin
          mem_wdata = rd_a;  // pull the parent down into the hole
        end
      end
      S_DN_RD: begin
        if (left_ok) begin
          rd_addr_a = dn_left[AW-1:0];
          rd_addr_b = dn_right[AW-1:0];
        end else begin
          mem_we = 1'b1;
        end
      end
      S_DN_CMP: begin
        cmp_a  = item;
        cmp_b  = best;
        mem_we = 1'b1;
        if (a_worse) begin
          mem_wdata = best;  // lift the better child into the hole
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      count           <= '0;
      order_max_first <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        order_max_first <= cfg_wr_data;
      end
      // Raise valid when a result is loaded, drop it once the result is taken.
      if (state == S_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res <= '0;
            if (command == CMD_INSERT) begin
              if (count == CW'(CAPACITY)) begin
                res_status <= ST_FULL;
                state      <= S_FIN;
              end else begin
                res_status <= ST_OK;
                item  <= '{key: sort_key, tag: tag_value, size: item_size};
                hole  <= count[AW-1:0];
                count <= count + 1'b1;
                state <= S_UP_RD;
              end
            end else begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_FIN;
              end else begin
                res_status <= ST_OK;
                hole  <= '0;
                count <= count - 1'b1;
                state <= S_DN_LOAD;
              end
            end
          end
        end
        S_UP_RD: begin
          // At the root the entry has been written; otherwise wait for the parent.
          state <= (hole == '0) ? S_FIN : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (a_worse) begin
            hole  <= up_parent;
            state <= S_UP_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_DN_LOAD: begin
          res   <= rd_a;
          item  <= rd_b;
          state <= S_DN_RD;
        end
        S_DN_RD: begin
          state <= left_ok ? S_DN_SEL : S_FIN;
        end
        S_DN_SEL: begin
          // Take the right child only when it exists and is strictly better.
          if (right_ok && a_worse) begin
            best     <= rd_b;
            best_idx <= dn_right[AW-1:0];
          end else begin
            best     <= rd_a;
            best_idx <= dn_left[AW-1:0];
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (a_worse) begin
            hole  <= best_idx;
            state <= S_DN_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // Hold the result until the output register is free.
          if (!out_valid || out_ready) begin
            status      <= res_status;
            out_key     <= res.key;
            out_tag     <= res.tag;
            out_size    <= res.size;
            entry_count <= count_wide[8:0];
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign count_wide = {9'b0, count};

  // Held count never passes capacity.
  `ASSERT_IMPLIES(a_count_cap, clk, rst, 1'b1, count <= CW'(CAPACITY))
  // The block is busy in the cycle after it takes an item.
  `ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)
  // A rejected item carries no entry.
  `ASSERT_IMPLIES(a_reject_zero, clk, rst, out_valid && status != ST_OK,
                  out_key == '0 && out_tag == '0 && out_size == '0)
  // A remove can never be rejected while entries are held.
  `ASSERT_IMPLIES(a_empty_count, clk, rst, out_valid && status == ST_EMPTY,
                  entry_count == '0)

endmodule
